>>> rtl/core/countdown_timer_controller_defines.svh
// Assertion macros shared by the countdown timer controller RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef COUNTDOWN_TIMER_CONTROLLER_DEFINES_SVH
`define COUNTDOWN_TIMER_CONTROLLER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define CTC_ASSERT_HOLD(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CTC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ctc_pkg.sv
// Shared constants and types of the countdown timer controller.
// No dependencies; every module uses it by scoped names.
package ctc_pkg;

    localparam int TIME_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int ACT_W    = 3;
    localparam int MODE_W   = 2;
    localparam int FLAG_W   = 8;
    localparam int PCT_W    = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIVD_W   = 32;
    localparam int DSR_W    = 16;
    localparam int RES_W    = MODE_W + 2 * TIME_W + 1 + FLAG_W + PCT_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // modes
    localparam logic [MODE_W-1:0] MODE_SETUP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALARM   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SLEEP   = 2'd3;

    // events
    localparam logic [ACT_W-1:0] ACT_BUTTON   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ENCODER  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FAST     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INACTIVE = 3'd4;

    // action flags
    localparam logic [FLAG_W-1:0] FL_NONE        = 8'h00;
    localparam logic [FLAG_W-1:0] FL_UPDATE      = 8'h01;
    localparam logic [FLAG_W-1:0] FL_START       = 8'h02;
    localparam logic [FLAG_W-1:0] FL_STOP        = 8'h04;
    localparam logic [FLAG_W-1:0] FL_ALARM_START = 8'h08;
    localparam logic [FLAG_W-1:0] FL_ALARM_STOP  = 8'h10;
    localparam logic [FLAG_W-1:0] FL_LIGHT_ON    = 8'h20;
    localparam logic [FLAG_W-1:0] FL_LIGHT_OFF   = 8'h40;
    localparam logic [FLAG_W-1:0] FL_TOGGLE      = 8'h80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_DIV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME = 2'd3;

    // reset values
    localparam logic [4:0]        RST_ENC_DIV  = 5'd4;
    localparam logic [11:0]       RST_STEP     = 12'd30;
    localparam logic [TIME_W-1:0] RST_MIN_TIME = 16'd30;
    localparam logic [TIME_W-1:0] RST_MAX_TIME = 16'd3600;
    localparam logic [TIME_W-1:0] DEFAULT_TIME = 16'd300;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

    typedef struct packed {
        logic latch_in;
        logic eval;
        logic div_start;
        logic div_prog;
        logic mul_load;
        logic apply;
        logic prog_const;
        logic prog_div;
        logic load_out;
    } ctc_cmd_t;

    typedef struct packed {
        logic enc_path;
        logic div_busy;
        logic div_done;
        logic clicks_zero;
        logic prog_needs_div;
    } ctc_sts_t;

endpackage

>>> rtl/core/countdown_timer_controller.sv
// Countdown timer controller. One event word in, one status word out. An
// encoder change in setup divides the encoder delta, and an event that leaves
// the timer running or in alarm with a nonzero target divides remaining*100 by
// the target. Both go through one shared restoring divider at one quotient bit
// per cycle, and no word needs more than one division. The block takes no new
// word until the current one has been loaded into the output register.
// A new word is taken while the previous result still waits on the output register.
module countdown_timer_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ctc_pkg::COUNT_W-1:0]       s_tdata,  // [31:0] encoder_count
    input  logic [ctc_pkg::ACT_W-1:0]         s_tuser,  // [2:0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] mode, [17:2] remaining_secs, [33:18] target_secs, [34] flash_on,
    // [42:35] action_flags, [49:43] progress_percent, [55:50] zero
    output logic [ctc_pkg::M_DATA_W-1:0]      m_tdata
);

    ctc_pkg::ctc_cmd_t           cmd;
    ctc_pkg::ctc_sts_t           sts;
    logic [ctc_pkg::RES_W-1:0]   result;

    ctc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_count  (s_tdata),
        .in_action (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

    assign m_tdata = ctc_pkg::M_DATA_W'(result);

endmodule

>>> rtl/core/ctc_divider.sv
// Restoring divider, one quotient bit per cycle, 32 steps per division.
// Depends on ctc_pkg for operand widths.
module ctc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ctc_pkg::DIVD_W-1:0]    dividend,
    input  logic [ctc_pkg::DSR_W-1:0]     divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ctc_pkg::DIVD_W-1:0]    quotient,
    output logic [ctc_pkg::DSR_W-1:0]     remainder
);

    localparam int STEP_W = $clog2(ctc_pkg::DIVD_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [ctc_pkg::DIVD_W-1:0]   dvd_reg;
    logic [ctc_pkg::DSR_W-1:0]    dsr_reg;
    logic [ctc_pkg::DSR_W-1:0]    rem_reg;
    logic [ctc_pkg::DSR_W:0]      trial;
    logic [ctc_pkg::DSR_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[ctc_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ctc_pkg::DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the quotient in where the dividend leaves
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[ctc_pkg::DSR_W]) begin
                rem_reg <= diff[ctc_pkg::DSR_W-1:0];
                dvd_reg <= {dvd_reg[ctc_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[ctc_pkg::DSR_W-1:0];
                dvd_reg <= {dvd_reg[ctc_pkg::DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/ctc_ctrl.sv
// Sequencer of the countdown timer controller: steps each word through
// evaluation, division, multiply and apply when needed, progress, output load. Uses ctc_pkg.
`include "countdown_timer_controller_defines.svh"

module ctc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ctc_pkg::ctc_sts_t sts,
    output ctc_pkg::ctc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EVAL     = 3'd1;
    localparam logic [2:0] ST_DIV_ENC  = 3'd2;
    localparam logic [2:0] ST_MUL      = 3'd3;
    localparam logic [2:0] ST_APPLY    = 3'd4;
    localparam logic [2:0] ST_PROG     = 3'd5;
    localparam logic [2:0] ST_DIV_PROG = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.enc_path) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_ENC;
                end else begin
                    state_next = ST_PROG;
                end
            end
            ST_DIV_ENC: begin
                if (sts.div_done) begin
                    state_next = sts.clicks_zero ? ST_PROG : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_PROG;
            end
            ST_PROG: begin
                if (sts.prog_needs_div) begin
                    cmd.div_start = 1'b1;
                    cmd.div_prog  = 1'b1;
                    state_next    = ST_DIV_PROG;
                end else begin
                    cmd.prog_const = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DIV_PROG: begin
                if (sts.div_done) begin
                    cmd.prog_div = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `CTC_ASSERT_IMPLY(a_start_free, cmd.div_start, !sts.div_busy, "divider started while busy")
    `CTC_ASSERT_IMPLY(a_ready_quiet, s_tready, !sts.div_busy, "input ready during a division")
    `CTC_ASSERT_NEXT(a_accept_eval, s_tvalid && s_tready, state_reg == ST_EVAL, "accept lost")

endmodule

>>> rtl/core/ctc_datapath.sv
// Datapath of the countdown timer controller: configuration, timer state,
// event rules, shared divider, click multiply and result register. Uses ctc_pkg.
`include "countdown_timer_controller_defines.svh"

module ctc_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctc_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [ctc_pkg::COUNT_W-1:0]      in_count,
    input  logic [ctc_pkg::ACT_W-1:0]        in_action,
    input  ctc_pkg::ctc_cmd_t                cmd,
    output ctc_pkg::ctc_sts_t                sts,
    output logic [ctc_pkg::RES_W-1:0]        result
);

    localparam int PROD_W = ctc_pkg::DIVD_W + 12;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NUM_W  = ctc_pkg::TIME_W + ctc_pkg::PCT_W;

    // configuration
    logic [4:0]                   enc_div_reg;
    logic [11:0]                  step_reg;
    logic [ctc_pkg::TIME_W-1:0]   min_reg;
    logic [ctc_pkg::TIME_W-1:0]   max_reg;

    // timer state
    logic [ctc_pkg::MODE_W-1:0]   mode_reg;
    logic [ctc_pkg::TIME_W-1:0]   target_reg;
    logic [ctc_pkg::TIME_W-1:0]   remaining_reg;
    logic [ctc_pkg::COUNT_W-1:0]  last_reg;
    logic                         flash_reg;

    // per-word working registers
    logic [ctc_pkg::ACT_W-1:0]    act_reg;
    logic [ctc_pkg::COUNT_W-1:0]  cnt_reg;
    logic [ctc_pkg::FLAG_W-1:0]   flags_reg;
    logic [ctc_pkg::PCT_W-1:0]    prog_reg;
    logic                         neg_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [ctc_pkg::RES_W-1:0]    out_reg;

    // event rules
    logic [ctc_pkg::MODE_W-1:0]   ev_mode;
    logic [ctc_pkg::TIME_W-1:0]   ev_remaining;
    logic [ctc_pkg::COUNT_W-1:0]  ev_last;
    logic                         ev_flash;
    logic [ctc_pkg::FLAG_W-1:0]   ev_flags;

    // divider operands
    logic [ctc_pkg::COUNT_W-1:0]  delta;
    logic                         delta_neg;
    logic [ctc_pkg::COUNT_W-1:0]  delta_mag;
    logic [NUM_W-1:0]             pct_num;
    logic [ctc_pkg::DIVD_W-1:0]   div_dividend;
    logic [ctc_pkg::DSR_W-1:0]    div_divisor;
    logic                         div_busy;
    logic                         div_done;
    logic [ctc_pkg::DIVD_W-1:0]   quo;
    logic [ctc_pkg::DSR_W-1:0]    rem;

    // target update
    logic signed [SUM_W-1:0]      step_signed;
    logic signed [SUM_W-1:0]      t_sum;
    logic [ctc_pkg::TIME_W-1:0]   t_new;
    logic [ctc_pkg::COUNT_W-1:0]  rem_ext;
    logic [ctc_pkg::COUNT_W-1:0]  last_new;
    logic [ctc_pkg::PCT_W-1:0]    pct_const;
    logic [ctc_pkg::PCT_W-1:0]    pct_div;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_div_reg <= ctc_pkg::RST_ENC_DIV;
            step_reg    <= ctc_pkg::RST_STEP;
            min_reg     <= ctc_pkg::RST_MIN_TIME;
            max_reg     <= ctc_pkg::RST_MAX_TIME;
        end else if (cfg_we) begin
            case (cfg_index)
                ctc_pkg::CFG_ENC_DIV:  enc_div_reg <= cfg_wdata[4:0];
                ctc_pkg::CFG_STEP:     step_reg    <= cfg_wdata[11:0];
                ctc_pkg::CFG_MIN_TIME: min_reg     <= cfg_wdata;
                ctc_pkg::CFG_MAX_TIME: max_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        ev_mode      = mode_reg;
        ev_remaining = remaining_reg;
        ev_last      = last_reg;
        ev_flash     = flash_reg;
        ev_flags     = ctc_pkg::FL_NONE;
        case (mode_reg)
            ctc_pkg::MODE_SETUP: begin
                if (act_reg == ctc_pkg::ACT_BUTTON) begin
                    ev_mode      = ctc_pkg::MODE_RUNNING;
                    ev_remaining = target_reg;
                    ev_flags     = ctc_pkg::FL_UPDATE | ctc_pkg::FL_START;
                end else if (act_reg == ctc_pkg::ACT_INACTIVE) begin
                    ev_mode  = ctc_pkg::MODE_SLEEP;
                    ev_flags = ctc_pkg::FL_UPDATE | ctc_pkg::FL_LIGHT_OFF;
                end
            end
            ctc_pkg::MODE_RUNNING: begin
                if (act_reg == ctc_pkg::ACT_BUTTON) begin
                    ev_mode      = ctc_pkg::MODE_SETUP;
                    ev_remaining = target_reg;
                    ev_flags     = ctc_pkg::FL_UPDATE | ctc_pkg::FL_STOP;
                end else if (act_reg == ctc_pkg::ACT_TICK) begin
                    if (remaining_reg != '0) begin
                        ev_remaining = remaining_reg - 1'b1;
                        ev_flags     = ctc_pkg::FL_UPDATE;
                        if (remaining_reg == ctc_pkg::TIME_W'(1)) begin
                            ev_mode  = ctc_pkg::MODE_ALARM;
                            ev_flash = 1'b1;
                            ev_flags = ctc_pkg::FL_UPDATE | ctc_pkg::FL_STOP
                                     | ctc_pkg::FL_ALARM_START;
                        end
                    end
                end else if (act_reg == ctc_pkg::ACT_ENCODER) begin
                    ev_last = cnt_reg;
                end
            end
            ctc_pkg::MODE_ALARM: begin
                if (act_reg == ctc_pkg::ACT_BUTTON || act_reg == ctc_pkg::ACT_ENCODER) begin
                    ev_mode      = ctc_pkg::MODE_SETUP;
                    ev_remaining = target_reg;
                    ev_flash     = 1'b0;
                    ev_last      = cnt_reg;
                    ev_flags     = ctc_pkg::FL_UPDATE | ctc_pkg::FL_ALARM_STOP
                                 | ctc_pkg::FL_LIGHT_ON;
                end else if (act_reg == ctc_pkg::ACT_FAST) begin
                    ev_flash = ~flash_reg;
                    ev_flags = ctc_pkg::FL_TOGGLE;
                end
            end
            ctc_pkg::MODE_SLEEP: begin
                if (act_reg == ctc_pkg::ACT_BUTTON || act_reg == ctc_pkg::ACT_ENCODER) begin
                    ev_mode  = ctc_pkg::MODE_SETUP;
                    ev_last  = cnt_reg;
                    ev_flags = ctc_pkg::FL_UPDATE | ctc_pkg::FL_LIGHT_ON;
                end
            end
            default: ;
        endcase
    end

    // encoder delta wraps at the count width; divide its magnitude
    assign delta     = cnt_reg - last_reg;
    assign delta_neg = delta[ctc_pkg::COUNT_W-1];
    assign delta_mag = delta_neg ? (ctc_pkg::COUNT_W'(0) - delta) : delta;
    assign pct_num   = NUM_W'(remaining_reg) * NUM_W'(ctc_pkg::PCT_FULL);

    always_comb begin
        if (cmd.div_prog) begin
            div_dividend = ctc_pkg::DIVD_W'(pct_num);
            div_divisor  = target_reg;
        end else begin
            div_dividend = delta_mag;
            div_divisor  = (enc_div_reg == '0) ? ctc_pkg::DSR_W'(1)
                                               : ctc_pkg::DSR_W'(enc_div_reg);
        end
    end

    ctc_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // target + clicks * step, clamp to min then max
    always_comb begin
        step_signed = $signed({2'b00, prod_reg});
        if (neg_reg) begin
            step_signed = -step_signed;
        end
        t_sum = $signed(SUM_W'(target_reg)) + step_signed;
        if (t_sum < $signed(SUM_W'(min_reg))) begin
            t_sum = $signed(SUM_W'(min_reg));
        end
        if (t_sum > $signed(SUM_W'(max_reg))) begin
            t_sum = $signed(SUM_W'(max_reg));
        end
        t_new = t_sum[ctc_pkg::TIME_W-1:0];
    end

    // last count advances by whole clicks only: drop the signed remainder
    assign rem_ext  = ctc_pkg::COUNT_W'(rem);
    assign last_new = neg_reg ? (cnt_reg + rem_ext) : (cnt_reg - rem_ext);

    always_comb begin
        if (target_reg == '0 || mode_reg == ctc_pkg::MODE_SETUP) begin
            pct_const = ctc_pkg::PCT_FULL;
        end else begin
            pct_const = ctc_pkg::PCT_ZERO;
        end
        if (quo > ctc_pkg::DIVD_W'(ctc_pkg::PCT_FULL)) begin
            pct_div = ctc_pkg::PCT_FULL;
        end else begin
            pct_div = quo[ctc_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ctc_pkg::MODE_SETUP;
            target_reg    <= ctc_pkg::DEFAULT_TIME;
            remaining_reg <= ctc_pkg::DEFAULT_TIME;
            last_reg      <= '0;
            flash_reg     <= 1'b0;
        end else if (cmd.eval) begin
            mode_reg      <= ev_mode;
            remaining_reg <= ev_remaining;
            last_reg      <= ev_last;
            flash_reg     <= ev_flash;
        end else if (cmd.apply) begin
            target_reg    <= t_new;
            remaining_reg <= t_new;
            last_reg      <= last_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            act_reg <= in_action;
            cnt_reg <= in_count;
        end
        if (cmd.eval) begin
            flags_reg <= ev_flags;
        end else if (cmd.apply) begin
            flags_reg <= ctc_pkg::FL_UPDATE;
        end
        if (cmd.div_start && !cmd.div_prog) begin
            neg_reg <= delta_neg;
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(quo) * PROD_W'(step_reg);
        end
        if (cmd.prog_const) begin
            prog_reg <= pct_const;
        end else if (cmd.prog_div) begin
            prog_reg <= pct_div;
        end
        if (cmd.load_out) begin
            out_reg <= {prog_reg, flags_reg, flash_reg, target_reg, remaining_reg, mode_reg};
        end
    end

    assign sts.enc_path       = (mode_reg == ctc_pkg::MODE_SETUP)
                              && (act_reg == ctc_pkg::ACT_ENCODER);
    assign sts.div_busy       = div_busy;
    assign sts.div_done       = div_done;
    assign sts.clicks_zero    = (quo == '0);
    assign sts.prog_needs_div = (target_reg != '0)
                              && (mode_reg == ctc_pkg::MODE_RUNNING
                                  || mode_reg == ctc_pkg::MODE_ALARM);
    assign result = out_reg;

    `CTC_ASSERT_HOLD(a_rem_le_target, remaining_reg <= target_reg, "remaining above target")
    `CTC_ASSERT_IMPLY(a_alarm_zero, mode_reg == ctc_pkg::MODE_ALARM, remaining_reg == '0, "alarm with time left")
    `CTC_ASSERT_IMPLY(a_flash_alarm, flash_reg, mode_reg == ctc_pkg::MODE_ALARM, "flash outside alarm")

endmodule
